// ===== design/modexp_pkg.sv =====
// shared types, constants and microprogram for the modular exponentiation block
`default_nettype none

package modexp_pkg;

    localparam int FIELD_BITS     = 63;
    localparam int IN_TDATA_BITS  = 192;
    localparam int OUT_TDATA_BITS = 64;
    localparam int OPERAND_BITS_DEFAULT = 63;

    localparam int UPC_BITS = 4;

    typedef logic [UPC_BITS-1:0] t_upc;

    // microprogram step addresses
    localparam t_upc A_IDLE    = 4'd0;
    localparam t_upc A_CHK_E   = 4'd1;
    localparam t_upc A_CHK_M   = 4'd2;
    localparam t_upc A_RED_GO  = 4'd3;
    localparam t_upc A_RED_RUN = 4'd4;
    localparam t_upc A_RED_WB  = 4'd5;
    localparam t_upc A_LOOP    = 4'd6;
    localparam t_upc A_MUL_GO  = 4'd7;
    localparam t_upc A_MUL_RUN = 4'd8;
    localparam t_upc A_MUL_WB  = 4'd9;
    localparam t_upc A_SQR_GO  = 4'd10;
    localparam t_upc A_SQR_RUN = 4'd11;
    localparam t_upc A_SQR_WB  = 4'd12;
    localparam t_upc A_EMIT    = 4'd13;
    localparam t_upc A_RET     = 4'd14;
    localparam t_upc A_ZERO    = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR_ACC,
        OP_RED_START,
        OP_MUL_START,
        OP_SQR_START,
        OP_MM_STEP,
        OP_WB_B,
        OP_WB_ACC,
        OP_WB_B_SHR,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_E_ZERO,
        C_M_ZERO,
        C_MM_BUSY,
        C_E_BIT_CLR,
        C_E_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // datapath flags the sequencer branches on
    typedef struct packed {
        logic in_valid;
        logic e_zero;
        logic m_zero;
        logic mm_busy;
        logic e_bit_clr;
        logic e_more;
        logic out_busy;
    } t_stat;

    function automatic t_uword uw(input t_op op, input t_cond cond, input t_upc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: a jump is taken when the condition holds, else fall through
    function automatic t_uword urom(input t_upc addr);
        t_uword w;
        unique case (addr)
            A_IDLE:    w = uw(OP_LOAD,      C_NO_IN,     A_IDLE);
            A_CHK_E:   w = uw(OP_NOP,       C_E_ZERO,    A_EMIT);
            A_CHK_M:   w = uw(OP_NOP,       C_M_ZERO,    A_ZERO);
            A_RED_GO:  w = uw(OP_RED_START, C_NEXT,      A_IDLE);
            A_RED_RUN: w = uw(OP_MM_STEP,   C_MM_BUSY,   A_RED_RUN);
            A_RED_WB:  w = uw(OP_WB_B,      C_NEXT,      A_IDLE);
            A_LOOP:    w = uw(OP_NOP,       C_E_BIT_CLR, A_SQR_GO);
            A_MUL_GO:  w = uw(OP_MUL_START, C_NEXT,      A_IDLE);
            A_MUL_RUN: w = uw(OP_MM_STEP,   C_MM_BUSY,   A_MUL_RUN);
            A_MUL_WB:  w = uw(OP_WB_ACC,    C_NEXT,      A_IDLE);
            A_SQR_GO:  w = uw(OP_SQR_START, C_NEXT,      A_IDLE);
            A_SQR_RUN: w = uw(OP_MM_STEP,   C_MM_BUSY,   A_SQR_RUN);
            A_SQR_WB:  w = uw(OP_WB_B_SHR,  C_E_MORE,    A_LOOP);
            A_EMIT:    w = uw(OP_EMIT,      C_OUT_BUSY,  A_EMIT);
            A_RET:     w = uw(OP_NOP,       C_ALWAYS,    A_IDLE);
            A_ZERO:    w = uw(OP_CLR_ACC,   C_ALWAYS,    A_EMIT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/modexp_mulmod.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle while stepped
`default_nettype none

module modexp_mulmod #(
    parameter int W = modexp_pkg::OPERAND_BITS_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic         i_step,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_mplier,
    input  wire logic [W-1:0] i_m,
    output logic              o_busy,
    output logic [W-1:0]      o_p
);
    import modexp_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_p;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_q;
    logic [CW-1:0] r_cnt;

    logic [W:0]   dbl;
    logic [W-1:0] d1;
    logic [W:0]   sum;
    logic [W-1:0] n_p;

    always_comb begin
        dbl = {r_p, 1'b0};
        d1  = (dbl >= {1'b0, i_m}) ? W'(dbl - {1'b0, i_m}) : W'(dbl);
        sum = {1'b0, d1} + {1'b0, r_a};
        if (r_q[W-1]) begin
            n_p = (sum >= {1'b0, i_m}) ? W'(sum - {1'b0, i_m}) : W'(sum);
        end else begin
            n_p = d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CW'(W);
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p <= '0;
            r_a <= i_a;
            r_q <= i_mplier;
        end else if (i_step) begin
            r_p <= n_p;
            r_q <= {r_q[W-2:0], 1'b0};
        end
    end

    // more bits left after the one in work this cycle
    assign o_busy = (r_cnt > CW'(1));
    assign o_p    = r_p;

    a_step_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_cnt != '0))
        else $error("multiplier stepped with no bits left");

    a_partial_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && i_m != '0) |-> (r_p < i_m))
        else $error("partial product not below modulus");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == CW'(W)))
        else $error("bit counter not set on load");

endmodule

`default_nettype wire

// ===== design/modexp_seq.sv =====
// microprogram sequencer: step counter, control store and branch logic
`default_nettype none

module modexp_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire modexp_pkg::t_stat i_stat,
    output modexp_pkg::t_op        o_op,
    output logic                   o_idle
);
    import modexp_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword word;
    logic   take;

    always_comb begin
        word = urom(r_upc);
        unique case (word.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_IN:     take = !i_stat.in_valid;
            C_E_ZERO:    take = i_stat.e_zero;
            C_M_ZERO:    take = i_stat.m_zero;
            C_MM_BUSY:   take = i_stat.mm_busy;
            C_E_BIT_CLR: take = i_stat.e_bit_clr;
            C_E_MORE:    take = i_stat.e_more;
            C_OUT_BUSY:  take = i_stat.out_busy;
            default:     take = 1'b0;
        endcase
        n_upc = take ? word.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_op   = word.op;
    assign o_idle = (r_upc == A_IDLE);

endmodule

`default_nettype wire

// ===== design/modular_exponentiation.sv =====
// modular exponentiation top level: datapath registers, stream ports, sequencer and multiplier
// flow from accept to result beat: the base is reduced mod the modulus, then for each exponent bit up to
//   the highest set one the accumulator is multiplied by the base if the bit is set and the base is squared
// a zero exponent, or a zero modulus with a nonzero exponent, goes straight to the result without the multiplier
// one item at a time; the next beat is taken once the sequencer has returned to idle after the result is raised;
//   the bit-serial multiplier (one multiplier bit per cycle) sets the pace
// a finished result waits in the output register while the next item is accepted
// synchronous active-low reset returns the sequencer to idle and drops the output valid
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // base_value [62:0], power [125:63], modulus [188:126], zero pad [191:189]
    input  wire logic [modexp_pkg::IN_TDATA_BITS-1:0] i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // residue [62:0], zero pad [63]
    output logic [modexp_pkg::OUT_TDATA_BITS-1:0]    o_m_tdata
);
    import modexp_pkg::*;

    localparam int W = OPERAND_BITS;

    logic [W-1:0] r_b;
    logic [W-1:0] r_e;
    logic [W-1:0] r_m;
    logic [W-1:0] r_acc;
    logic         r_tvalid;
    logic [FIELD_BITS-1:0] r_res;

    t_op   op;
    logic  idle;
    t_stat stat;

    logic         mm_load;
    logic         mm_step;
    logic         mm_busy;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_q;
    logic [W-1:0] mm_p;
    logic         out_busy;
    logic         emit;
    logic [FIELD_BITS-1:0] acc_ext;

    assign out_busy = r_tvalid && !i_m_tready;
    assign emit     = (op == OP_EMIT) && !out_busy;

    always_comb begin
        stat.in_valid  = i_s_tvalid;
        stat.e_zero    = (r_e == '0);
        stat.m_zero    = (r_m == '0);
        stat.mm_busy   = mm_busy;
        stat.e_bit_clr = !r_e[0];
        stat.e_more    = |r_e[W-1:1];
        stat.out_busy  = out_busy;
    end

    always_comb begin
        mm_load = 1'b0;
        mm_a    = r_b;
        mm_q    = r_b;
        unique case (op)
            OP_RED_START: begin
                // base mod m is 1 * base mod m
                mm_load = 1'b1;
                mm_a    = W'(1);
            end
            OP_MUL_START: begin
                mm_load = 1'b1;
                mm_q    = r_acc;
            end
            OP_SQR_START: begin
                mm_load = 1'b1;
            end
            default: begin
                mm_load = 1'b0;
            end
        endcase
    end

    assign mm_step = (op == OP_MM_STEP);

    always_comb begin
        acc_ext = '0;
        acc_ext[W-1:0] = r_acc;
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_LOAD: begin
                if (i_s_tvalid) begin
                    r_b   <= i_s_tdata[W-1:0];
                    r_e   <= i_s_tdata[FIELD_BITS +: W];
                    r_m   <= i_s_tdata[2*FIELD_BITS +: W];
                    r_acc <= W'(1);
                end
            end
            OP_CLR_ACC:  r_acc <= '0;
            OP_WB_B:     r_b   <= mm_p;
            OP_WB_ACC:   r_acc <= mm_p;
            OP_WB_B_SHR: begin
                r_b <= mm_p;
                r_e <= r_e >> 1;
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_res <= acc_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (emit) begin
            r_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    modexp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (op),
        .o_idle  (idle)
    );

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mm_load),
        .i_step   (mm_step),
        .i_a      (mm_a),
        .i_mplier (mm_q),
        .i_m      (r_m),
        .o_busy   (mm_busy),
        .o_p      (mm_p)
    );

    assign o_s_tready = idle;
    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = {{(OUT_TDATA_BITS-FIELD_BITS){1'b0}}, r_res};

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_m_tvalid && !emit)
        else $error("result beat not raised or emitted twice");

    a_idle_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !mm_load && !mm_step)
        else $error("multiplier driven while waiting for an item");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the modular exponentiation block: directed, random and stall tests
module testbench;

    import modexp_pkg::FIELD_BITS;
    import modexp_pkg::IN_TDATA_BITS;
    import modexp_pkg::OUT_TDATA_BITS;

    typedef logic [FIELD_BITS-1:0] t_word;

    localparam t_word WORD_MAX       = '1;
    localparam int    WATCHDOG_LIMIT = 50000;
    localparam int    SETTLE_CYCLES  = 64;
    localparam int    REPORT_LIMIT   = 10;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      s_tvalid   = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_tdata    = '0;
    logic                      m_tready   = 1'b0;
    logic                      o_s_tready;
    logic                      o_m_tvalid;
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;

    t_word residue_queue[$];
    int    error_count   = 0;
    int    quiet_cycles  = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    hold_request  = 0;
    int    hold_left     = 0;

    modular_exponentiation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // base^power mod modulus by right-to-left square-and-multiply on exact wide products
    function automatic t_word expected_residue(input t_word base_value, input t_word power,
                                               input t_word modulus);
        logic [127:0] mod_wide;
        logic [127:0] square;
        logic [127:0] running;
        int           bit_idx;
        if (power == '0) begin
            return t_word'(1);
        end
        if (modulus == '0) begin
            return '0;
        end
        mod_wide = {65'd0, modulus};
        square   = {65'd0, base_value} % mod_wide;
        running  = 128'd1;
        for (bit_idx = 0; bit_idx < FIELD_BITS; bit_idx++) begin
            if (power[bit_idx]) begin
                running = (running * square) % mod_wide;
            end
            square = (square * square) % mod_wide;
        end
        return running[FIELD_BITS-1:0];
    endfunction

    function automatic t_word random_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[FIELD_BITS-1:0];
    endfunction

    task automatic flag_residue_error(input string what, input t_word want, input t_word got);
        if (error_count < REPORT_LIMIT) begin
            $display("residue %s: expected %h, got %h", what, want, got);
        end
        error_count++;
    endtask

    // offer one beat, with random gaps before it, and log the expected residue on accept
    task automatic send_item(input t_word base_value, input t_word power, input t_word modulus);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, modulus, power, base_value};
        do @(posedge i_clk); while (!o_s_tready);
        residue_queue.push_back(expected_residue(base_value, power, modulus));
    endtask

    // stop offering and wait for every outstanding residue
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (residue_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item(input int max_power_bits);
        t_word base_value;
        t_word power;
        t_word modulus;
        int    pick;
        int    width;

        pick = $urandom_range(9, 0);
        if (pick < 6)      base_value = random_word();
        else if (pick < 9) base_value = t_word'($urandom_range(255, 0));
        else               base_value = WORD_MAX;

        pick = $urandom_range(19, 0);
        if (pick < 12)      modulus = random_word();
        else if (pick < 17) modulus = t_word'($urandom_range(1000, 1));
        else if (pick < 18) modulus = t_word'(1);
        else                modulus = WORD_MAX;
        if (modulus == '0) modulus = t_word'(1);

        // full-length exponents are slow, so most exponents are short
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            power = random_word();
        end else if (pick < 13) begin
            power = '0;
        end else begin
            width = $urandom_range(max_power_bits, 1);
            power = random_word() & ((t_word'(1) << width) - t_word'(1));
            power[width-1] = 1'b1;
        end
        send_item(base_value, power, modulus);
    endtask

    task automatic test_zero_exponent();
        send_item('0, '0, t_word'(1));
        send_item(WORD_MAX, '0, WORD_MAX);
        send_item(WORD_MAX, '0, t_word'(1));
        send_item(t_word'(3), '0, '0);
        drain_results();
    endtask

    task automatic test_degenerate_modulus();
        send_item(t_word'(5), t_word'(3), t_word'(1));
        send_item(t_word'(7), t_word'(9), '0);
        send_item(WORD_MAX, t_word'(1), '0);
        drain_results();
    endtask

    task automatic test_operand_extremes();
        send_item('0, t_word'(5), t_word'(13));
        send_item(WORD_MAX, t_word'(1), WORD_MAX);
        send_item(WORD_MAX - t_word'(1), t_word'(2), WORD_MAX);
        send_item(t_word'(2), t_word'(62), WORD_MAX);
        send_item(t_word'(123456789), t_word'(1), t_word'(1000));
        send_item(t_word'(1), WORD_MAX, t_word'(2));
        send_item(WORD_MAX, WORD_MAX, WORD_MAX - t_word'(1));
        send_item(WORD_MAX, t_word'(1) << 62, (t_word'(1) << 62) + t_word'(1));
        drain_results();
    endtask

    // receiver holds off long enough that the output register and the engine both fill
    task automatic test_output_backpressure();
        int n;
        hold_request = 4000;
        for (n = 0; n < 6; n++) begin
            send_random_item(8);
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < count; n++) begin
            send_random_item(10);
        end
        drain_results();
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (residue_queue.size() == 0) begin
                flag_residue_error("unexpected beat", '0, o_m_tdata[FIELD_BITS-1:0]);
            end else begin
                want = residue_queue.pop_front();
                if (o_m_tdata[FIELD_BITS-1:0] !== want) begin
                    flag_residue_error("mismatch", want, o_m_tdata[FIELD_BITS-1:0]);
                end
            end
        end
    end

    // ends the run when neither side has moved a beat for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 57;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_exponent();
        test_degenerate_modulus();
        test_operand_extremes();
        test_output_backpressure();
        test_random_traffic(27, 11, 57);
        test_random_traffic(26, 57, 11);
        test_random_traffic(26, 0, 0);

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
